>>> sv/pca_pkg.sv
// Shared constants and types for the PID controller block.
package pca_pkg;

	// Data formats
	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int DT_W      = 24;
	localparam int BOUND_W   = 31;
	localparam int CFG_IDX_W = 3;

	// Rate divider: (|diff| << FRAC_W) / step_time
	localparam int DIV_NUM_W = DATA_W + FRAC_W;
	localparam int DIV_DEN_W = DT_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_DRIVE_FLOOR   = 3'd3,
		REG_DRIVE_CEILING = 3'd4,
		REG_WINDUP_BOUND  = 3'd5
	} cfg_reg_t;

	// Register reset values (Q15.16)
	localparam logic signed [DATA_W-1:0] RST_GAIN_P        = 32'sd65536;
	localparam logic signed [DATA_W-1:0] RST_GAIN_I        = 32'sd0;
	localparam logic signed [DATA_W-1:0] RST_GAIN_D        = 32'sd0;
	localparam logic signed [DATA_W-1:0] RST_DRIVE_FLOOR   = -32'sd65536000;
	localparam logic signed [DATA_W-1:0] RST_DRIVE_CEILING = 32'sd65536000;
	localparam logic [BOUND_W-1:0]       RST_WINDUP_BOUND  = 31'd32768000;

endpackage

>>> sv/pca_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
module pca_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pca_pkg::DIV_NUM_W-1:0]   num,
	input  logic [pca_pkg::DIV_DEN_W-1:0]   den,
	output logic                            done,
	output logic [pca_pkg::DIV_NUM_W-1:0]   quo
);

	logic [pca_pkg::DIV_NUM_W-1:0] num_q;
	logic [pca_pkg::DIV_DEN_W-1:0] den_q;
	logic [pca_pkg::DIV_DEN_W-1:0] rem_q;
	logic [pca_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [pca_pkg::DIV_DEN_W:0]   rem_sh;
	logic [pca_pkg::DIV_DEN_W+1:0] trial;

	// Shift in next dividend bit and try subtracting the divisor
	assign rem_sh = {rem_q, num_q[pca_pkg::DIV_NUM_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};

	// Control: busy until all DIV_NUM_W quotient bits are formed, then a one-cycle done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == pca_pkg::DIV_CNT_W'(pca_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[pca_pkg::DIV_DEN_W+1]) begin
				rem_q <= trial[pca_pkg::DIV_DEN_W-1:0];
				num_q <= {num_q[pca_pkg::DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[pca_pkg::DIV_DEN_W-1:0];
				num_q <= {num_q[pca_pkg::DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

>>> sv/pid_controller_antiwindup_top.sv
// PID controller with integral clamp and derivative on measurement, Q15.16 fixed point.
//
// Channel  Dir   Handshake                 Payload
// in       in    in_valid / in_stall       target, sensed, step_time, restart
// out      out   out_valid / out_stall     drive
// cfg      in    cfg_we (no wait)          cfg_index, cfg_data
//
// Restart or a zero step_time: the item goes straight to S_DONE, skipping the arithmetic.
// First update after a clear: shared 33x33 multiplier, no rate divide, zero derivative term.
// Other updates also run the 48-step rate divider (one bit per cycle).
// arst_n clears state, config registers to their reset values and the output register.
// in_stall is high while an item is in work; out_stall only holds the final step.
module pid_controller_antiwindup_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input item
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pca_pkg::DATA_W-1:0]     target,
	input  logic signed [pca_pkg::DATA_W-1:0]     sensed,
	input  logic        [pca_pkg::DT_W-1:0]       step_time,
	input  logic                                  restart,
	// result item
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pca_pkg::DATA_W-1:0]     drive,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic        [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [pca_pkg::DATA_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_MP, S_MI, S_TSAT, S_MDT, S_ISAT, S_CLAMP, S_DIV,
		S_DWAIT, S_RATE, S_MD, S_DSAT, S_SUM, S_CLIP, S_DONE
	} state_t;

	localparam logic signed [pca_pkg::DATA_W-1:0] S32_MAX = {1'b0, {(pca_pkg::DATA_W-1){1'b1}}};
	localparam logic signed [pca_pkg::DATA_W-1:0] S32_MIN = {1'b1, {(pca_pkg::DATA_W-1){1'b0}}};

	// Product >>> 16 (floor), saturated to 32 bits
	function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
		logic [18:0] hi;
		hi = p[65:47];
		if (hi == '0 || hi == '1)
			return p[47:16];
		else if (p[65])
			return S32_MIN;
		else
			return S32_MAX;
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		if (x[32] != x[31])
			return x[32] ? S32_MIN : S32_MAX;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
		if (x[33:31] == 3'b000 || x[33:31] == 3'b111)
			return x[31:0];
		else
			return x[33] ? S32_MIN : S32_MAX;
	endfunction

	// Configuration registers
	logic signed [pca_pkg::DATA_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic signed [pca_pkg::DATA_W-1:0]  floor_q, ceiling_q;
	logic        [pca_pkg::BOUND_W-1:0] windup_q;

	// Controller state
	logic signed [pca_pkg::DATA_W-1:0]  accum_q;
	logic signed [pca_pkg::DATA_W-1:0]  last_q;
	logic                               fresh_q;

	// Sequencer and datapath registers
	state_t                             state_q;
	logic                               out_valid_q;
	logic signed [pca_pkg::DATA_W-1:0]  drive_q;
	logic signed [pca_pkg::DATA_W-1:0]  sensed_q;
	logic        [pca_pkg::DT_W-1:0]    dt_q;
	logic signed [pca_pkg::DATA_W-1:0]  err_q, diff_q, p_q, tmp_q, rate_q, d_q, res_q;
	logic signed [65:0]                 prod_q;

	// Shared multiplier
	logic signed [32:0]                 mul_a, mul_b;
	logic signed [65:0]                 mul_p;

	// Combinational helpers
	logic                               in_fire, out_free;
	logic signed [32:0]                 acc_sum, bound_pos, bound_neg;
	logic        [pca_pkg::DATA_W-1:0]  diff_abs;
	logic                               div_start, div_done;
	logic        [pca_pkg::DIV_NUM_W-1:0] div_quo;
	logic                               quo_big;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_MP: begin
				mul_a = 33'(gain_p_q);
				mul_b = 33'(err_q);
			end
			S_MI: begin
				mul_a = 33'(gain_i_q);
				mul_b = 33'(err_q);
			end
			S_MDT: begin
				mul_a = 33'(tmp_q);
				mul_b = $signed({9'b0, dt_q});
			end
			S_MD: begin
				mul_a = -33'(gain_d_q);
				mul_b = 33'(rate_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Integral update and clamp
	assign acc_sum   = 33'(accum_q) + 33'(tmp_q);
	assign bound_pos = $signed({2'b00, windup_q});
	assign bound_neg = -bound_pos;

	// Rate divider: magnitude of measurement change over step_time
	assign diff_abs  = diff_q[pca_pkg::DATA_W-1] ? pca_pkg::DATA_W'(-diff_q)
	                                             : pca_pkg::DATA_W'(diff_q);
	assign div_start = (state_q == S_DIV);
	assign quo_big   = |div_quo[pca_pkg::DIV_NUM_W-1:pca_pkg::DATA_W-1];

	pca_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({diff_abs, {pca_pkg::FRAC_W{1'b0}}}),
		.den   (dt_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= pca_pkg::RST_GAIN_P;
			gain_i_q  <= pca_pkg::RST_GAIN_I;
			gain_d_q  <= pca_pkg::RST_GAIN_D;
			floor_q   <= pca_pkg::RST_DRIVE_FLOOR;
			ceiling_q <= pca_pkg::RST_DRIVE_CEILING;
			windup_q  <= pca_pkg::RST_WINDUP_BOUND;
		end else if (cfg_we) begin
			case (pca_pkg::cfg_reg_t'(cfg_index))
				pca_pkg::REG_GAIN_P:        gain_p_q  <= cfg_data;
				pca_pkg::REG_GAIN_I:        gain_i_q  <= cfg_data;
				pca_pkg::REG_GAIN_D:        gain_d_q  <= cfg_data;
				pca_pkg::REG_DRIVE_FLOOR:   floor_q   <= cfg_data;
				pca_pkg::REG_DRIVE_CEILING: ceiling_q <= cfg_data;
				pca_pkg::REG_WINDUP_BOUND:  windup_q  <= cfg_data[pca_pkg::BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer with controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			accum_q     <= '0;
			last_q      <= '0;
			fresh_q     <= 1'b1;
			sensed_q    <= '0;
			dt_q        <= '0;
			err_q       <= '0;
			diff_q      <= '0;
			p_q         <= '0;
			tmp_q       <= '0;
			rate_q      <= '0;
			d_q         <= '0;
			res_q       <= '0;
			prod_q      <= '0;
		end else begin
			// The final step reloads the output register itself
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sensed_q <= sensed;
						dt_q     <= step_time;
						err_q    <= sat33(33'(target) - 33'(sensed));
						diff_q   <= sat33(33'(sensed) - 33'(last_q));
						if (restart) begin
							accum_q <= '0;
							last_q  <= '0;
							fresh_q <= 1'b1;
							res_q   <= '0;
							state_q <= S_DONE;
						end else if (step_time == '0) begin
							res_q   <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_MP;
						end
					end
				end
				S_MP: begin
					prod_q  <= mul_p;
					state_q <= S_MI;
				end
				S_MI: begin
					p_q     <= qsat(prod_q);
					prod_q  <= mul_p;
					state_q <= S_TSAT;
				end
				S_TSAT: begin
					tmp_q   <= qsat(prod_q);
					state_q <= S_MDT;
				end
				S_MDT: begin
					prod_q  <= mul_p;
					state_q <= S_ISAT;
				end
				S_ISAT: begin
					tmp_q   <= qsat(prod_q);
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (acc_sum > bound_pos)
						accum_q <= bound_pos[31:0];
					else if (acc_sum < bound_neg)
						accum_q <= bound_neg[31:0];
					else
						accum_q <= acc_sum[31:0];
					if (fresh_q) begin
						d_q     <= '0;
						state_q <= S_SUM;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done)
						state_q <= S_RATE;
				end
				S_RATE: begin
					// Truncated toward zero, then saturated by sign
					if (diff_q[pca_pkg::DATA_W-1])
						rate_q <= quo_big ? S32_MIN
						                  : -$signed(div_quo[pca_pkg::DATA_W-1:0]);
					else
						rate_q <= quo_big ? S32_MAX
						                  : $signed(div_quo[pca_pkg::DATA_W-1:0]);
					state_q <= S_MD;
				end
				S_MD: begin
					prod_q  <= mul_p;
					state_q <= S_DSAT;
				end
				S_DSAT: begin
					d_q     <= qsat(prod_q);
					state_q <= S_SUM;
				end
				S_SUM: begin
					res_q   <= sat34(34'(p_q) + 34'(accum_q) + 34'(d_q));
					state_q <= S_CLIP;
				end
				S_CLIP: begin
					// When the limits cross, a result above the ceiling takes the ceiling and any other takes the floor
					if (res_q > ceiling_q)
						res_q <= ceiling_q;
					else if (res_q < floor_q)
						res_q <= floor_q;
					last_q  <= sensed_q;
					fresh_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						drive_q     <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the fixed-point PID controller with integral clamp.
`timescale 1ns / 100ps

module testbench;
	import pca_pkg::*;

	// Spare register indexes; writes to them must leave every setting alone
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;
	localparam int ITEMS_PER_SETTING = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DATA_W-1:0] target = '0;
	logic signed [DATA_W-1:0] sensed = '0;
	logic [DT_W-1:0] step_time = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] drive;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the settings
	logic signed [DATA_W-1:0] kp = RST_GAIN_P;
	logic signed [DATA_W-1:0] ki = RST_GAIN_I;
	logic signed [DATA_W-1:0] kd = RST_GAIN_D;
	logic signed [DATA_W-1:0] out_lo = RST_DRIVE_FLOOR;
	logic signed [DATA_W-1:0] out_hi = RST_DRIVE_CEILING;
	logic [BOUND_W-1:0] int_bound = RST_WINDUP_BOUND;

	// Predictor copy of the controller state
	logic signed [DATA_W-1:0] integral_acc = '0;
	logic signed [DATA_W-1:0] prev_sensed = '0;
	logic first_update = 1'b1;

	logic signed [DATA_W-1:0] drive_expected[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	pid_controller_antiwindup_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target(target),
		.sensed(sensed),
		.step_time(step_time),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Saturate to signed 32 bits
	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q16 product, floored, saturated
	function automatic longint qmul(input longint a, input longint b);
		return sat32((a * b) >>> FRAC_W);
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] val);
		case (idx)
			REG_GAIN_P: kp = val;
			REG_GAIN_I: ki = val;
			REG_GAIN_D: kd = val;
			REG_DRIVE_FLOOR: out_lo = val;
			REG_DRIVE_CEILING: out_hi = val;
			REG_WINDUP_BOUND: int_bound = val[BOUND_W-1:0];
			default: ;
		endcase
	endfunction

	// Works out the drive for one update and advances the controller state
	function automatic logic signed [DATA_W-1:0] next_drive(
		input logic signed [DATA_W-1:0] tgt,
		input logic signed [DATA_W-1:0] meas,
		input logic [DT_W-1:0] dt,
		input logic rst);
		longint span, bnd, err, p_part, acc, d_part, diff, rate, sum;
		if (rst) begin
			integral_acc = '0;
			prev_sensed = '0;
			first_update = 1'b1;
			return '0;
		end
		if (dt == '0)
			return '0;
		span = dt;
		bnd = int_bound;
		err = sat32(longint'(tgt) - longint'(meas));
		p_part = qmul(kp, err);
		acc = longint'(integral_acc) + qmul(qmul(ki, err), span);
		if (acc > bnd)
			acc = bnd;
		else if (acc < -bnd)
			acc = -bnd;
		integral_acc = acc[DATA_W-1:0];
		d_part = 0;
		// derivative acts on the measurement and is skipped right after a clear
		if (!first_update) begin
			diff = sat32(longint'(meas) - longint'(prev_sensed));
			rate = sat32((diff * 65536) / span);
			d_part = sat32((-(longint'(kd) * rate)) >>> FRAC_W);
		end
		prev_sensed = meas;
		first_update = 1'b0;
		sum = sat32(p_part + acc + d_part);
		if (sum > longint'(out_hi))
			sum = out_hi;
		else if (sum < longint'(out_lo))
			sum = out_lo;
		return sum[DATA_W-1:0];
	endfunction

	// Offer one item after a random gap; record its drive once accepted
	task automatic send_item(input logic signed [DATA_W-1:0] tgt,
		input logic signed [DATA_W-1:0] meas, input logic [DT_W-1:0] dt,
		input logic rst);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target <= tgt;
		sensed <= meas;
		step_time <= dt;
		restart <= rst;
		do
			@(posedge clk);
		while (in_stall);
		drive_expected.push_back(next_drive(tgt, meas, dt, rst));
	endtask

	// Stop offering and wait until every pending drive has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_reg(idx, val);
	endtask

	task automatic set_regs(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
		input logic [DATA_W-1:0] gd, input logic [DATA_W-1:0] lo,
		input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] bnd);
		drain();
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_DRIVE_FLOOR, lo);
		write_reg(REG_DRIVE_CEILING, hi);
		write_reg(REG_WINDUP_BOUND, bnd);
		cfg_we <= 1'b0;
	endtask

	// Mostly values within +/-span, sometimes the full range or an extreme
	function automatic logic signed [DATA_W-1:0] pick_value(input int span);
		int v;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: begin
				v = int'($urandom_range(0, 2 * span)) - span;
				return v;
			end
		endcase
	endfunction

	// Reset settings: plain P control, restart and zero step, saturating error
	task automatic test_defaults();
		send_item(32'sd655360, 32'sd163840, 24'd655, 1'b0);
		send_item(32'sd720896, 32'sd131072, 24'd655, 1'b0);
		send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 24'd65536, 1'b0);
		send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFF_FFFF, 1'b0);
		send_item(32'sd12345, -32'sd54321, 24'd0, 1'b0);
		send_item(32'sd99999, -32'sd1, 24'd655, 1'b1);
		send_item(32'sd0, 32'sd0, 24'd0, 1'b1);
	endtask

	// Extreme gains and limits with extreme fields and time steps
	task automatic test_extremes();
		set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 24'd1, 1'b0);
		send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 24'd1, 1'b0);
		send_item(32'sd0, 32'sh7FFF_FFFF, 24'hFF_FFFF, 1'b0);
		send_item(-32'sd1, 32'sd1, 24'hFF_FFFF, 1'b0);
		send_item(32'sd1, -32'sd1, 24'd1, 1'b0);
		set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			32'h0000_0000, 32'hFFFF_FFFF);
		send_item(32'sd65536, -32'sd65536, 24'd1, 1'b0);
		send_item(-32'sd65536, 32'sd65536, 24'd3, 1'b0);
	endtask

	// Floor above ceiling, a zero and a small integral bound, spare register indexes
	task automatic test_clamps();
		set_regs(32'd131072, 32'd65536, 32'd32768, 32'd6553600, -32'd6553600, 32'd0);
		send_item(32'sd65536000, 32'sd0, 24'd65536, 1'b0);
		send_item(-32'sd65536000, 32'sd0, 24'd65536, 1'b0);
		send_item(32'sd0, 32'sd0, 24'd65536, 1'b0);
		drain();
		write_reg(IDX_SPARE_A, $urandom);
		write_reg(IDX_SPARE_B, $urandom);
		cfg_we <= 1'b0;
		send_item(32'sd655360, 32'sd65536, 24'd32768, 1'b0);
		// a small bound: the integral walks into the clamp and back out
		set_regs(32'd0, 32'd65536, 32'd0, -32'd65536000, 32'd65536000, 32'd98304);
		send_item(32'sd65536, 32'sd0, 24'd65536, 1'b0);
		send_item(32'sd65536, 32'sd0, 24'd65536, 1'b0);
		send_item(-32'sd196608, 32'sd0, 24'd65536, 1'b0);
		send_item(-32'sd196608, 32'sd0, 24'd65536, 1'b0);
	endtask

	// Output held off for a long stretch while items keep coming
	task automatic test_backpressure();
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_item(pick_value(32'sd6553600), pick_value(32'sd6553600),
				DT_W'($urandom_range(1, 65536)), 1'b0);
	endtask

	// Random updates under a fresh random setting every ITEMS_PER_SETTING items
	task automatic test_random(input int count, input int send_pct, input int recv_pct);
		logic signed [DATA_W-1:0] tgt, meas, lo, hi;
		logic [DT_W-1:0] dt;
		logic rst;
		int pick;
		for (int n = 0; n < count; n++) begin
			if (n % ITEMS_PER_SETTING == 0) begin
				lo = -pick_value(32'sd65536000);
				hi = pick_value(32'sd65536000);
				if ($urandom_range(0, 3) != 0 && lo > hi) begin
					tgt = lo;
					lo = hi;
					hi = tgt;
				end
				case ($urandom_range(0, 3))
					0: dt = '0;
					1: dt = '1;
					default: dt = DT_W'($urandom_range(0, 65536000));
				endcase
				set_regs(pick_value(32'sd262144), pick_value(32'sd262144),
					pick_value(32'sd65536), lo, hi,
					$urandom_range(0, 9) == 0 ? $urandom : {8'(dt >> 16), 24'(dt)});
				send_idle_pct = send_pct;
				stall_pct = recv_pct;
			end
			rst = ($urandom_range(0, 99) < 4);
			pick = $urandom_range(0, 99);
			if (pick < 4)
				dt = '0;
			else if (pick < 74)
				dt = DT_W'($urandom_range(1, 65536));
			else if (pick < 84)
				dt = DT_W'($urandom_range(1, 16));
			else
				dt = DT_W'($urandom_range(1, 24'hFF_FFFF));
			tgt = pick_value(32'sd6553600);
			// measurement mostly tracks the setpoint
			if ($urandom_range(0, 3) == 0)
				meas = pick_value(32'sd6553600);
			else
				meas = tgt + pick_value(32'sd655360);
			send_item(tgt, meas, dt, rst);
		end
	endtask

	// Drive out_stall and check each accepted drive against the oldest prediction
	always @(posedge clk) begin
		logic signed [DATA_W-1:0] want;
		logic bad;
		if (out_valid && !out_stall) begin
			want = 'x;
			bad = 1'b1;
			if (drive_expected.size() != 0) begin
				want = drive_expected.pop_front();
				bad = (drive !== want);
			end
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("drive mismatch: expected %0d, got %0d", want, drive);
			end
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extremes();
		test_clamps();
		test_random(450, 0, 0);
		test_random(450, 80, 0);
		test_backpressure();
		test_random(450, 0, 80);
		test_random(450, 35, 35);
		drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hard limit on the run
	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
sv/pca_pkg.sv
sv/pca_div.sv
sv/pid_controller_antiwindup_top.sv
tb/sv/testbench.sv
